[rtl/acioe_pkg.sv]
// Shared types and constants for the insertion-order eviction cache.
package acioe_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = 4;
	localparam int AGE_W   = 14;

	localparam logic [AGE_W-1:0] AGE_NEW = AGE_W'(9999);
	localparam logic [AGE_W-1:0] AGE_TOP = '1;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic               command;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] payload;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted;
		logic [VALUE_W-1:0] found_value;
	} out_item_t;

	typedef struct packed {
		logic             act;
		logic             cmd;
		logic             done;
		logic [AGE_W-1:0] sel_age;
	} scan_ctl_t;

endpackage

[rtl/acioe_cell.sv]
// One cache entry with its stage of the search chain.
module acioe_cell #(
	parameter int CELL_IDX   = 0,
	parameter int IDX_W      = 4,
	parameter int KEY_BITS   = acioe_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = acioe_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acioe_pkg::scan_ctl_t  in_ctl,
	input  logic [KEY_BITS-1:0]   in_key,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [IDX_W-1:0]      in_idx,
	output acioe_pkg::scan_ctl_t  out_ctl,
	output logic [KEY_BITS-1:0]   out_key,
	output logic [VALUE_BITS-1:0] out_value,
	output logic [IDX_W-1:0]      out_idx,
	input  logic                  commit_en,
	input  logic [IDX_W-1:0]      commit_idx,
	input  logic [KEY_BITS-1:0]   commit_key,
	input  logic [VALUE_BITS-1:0] commit_value
);
	import acioe_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [AGE_W-1:0]      age_q;

	scan_ctl_t             ctl_nxt;
	logic [VALUE_BITS-1:0] value_nxt;
	logic [IDX_W-1:0]      idx_nxt;
	scan_ctl_t             ctl_q;
	logic [KEY_BITS-1:0]   skey_q;
	logic [VALUE_BITS-1:0] svalue_q;
	logic [IDX_W-1:0]      sidx_q;

	// A lookup keeps the first match; an insert keeps the first empty entry or the oldest one.
	always_comb begin
		ctl_nxt   = in_ctl;
		value_nxt = in_value;
		idx_nxt   = in_idx;
		if (in_ctl.act && !in_ctl.done) begin
			if (in_ctl.cmd == CMD_LOOKUP) begin
				if (valid_q && key_q == in_key) begin
					ctl_nxt.done = 1'b1;
					idx_nxt      = MY_IDX;
					value_nxt    = value_q;
				end
			end else begin
				if (!valid_q) begin
					ctl_nxt.done = 1'b1;
					idx_nxt      = MY_IDX;
				end else if (age_q < in_ctl.sel_age) begin
					ctl_nxt.sel_age = age_q;
					idx_nxt         = MY_IDX;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		skey_q   <= in_key;
		svalue_q <= value_nxt;
		sidx_q   <= idx_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (commit_en) begin
			if (commit_idx == MY_IDX) begin
				valid_q <= 1'b1;
				age_q   <= AGE_NEW;
			end else if (valid_q && age_q != '0) begin
				age_q <= age_q - AGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en && commit_idx == MY_IDX) begin
			key_q   <= commit_key;
			value_q <= commit_value;
		end
	end

	assign out_ctl   = ctl_q;
	assign out_key   = skey_q;
	assign out_value = svalue_q;
	assign out_idx   = sidx_q;

endmodule

[rtl/assoc_cache_insertion_order_evict_core.sv]
// Top level of the fully associative cache with insertion-order eviction.
//
//   channel   signals                      accepted when
//   --------  ---------------------------  ---------------------------
//   request   start, busy, request         start high and busy low
//   result    result_valid, result         every cycle result_valid is high
//
// Each item is searched along the chain one cell a cycle, through a register in every
// cell; the chosen entry is written and the others aged as the result is registered.
// Busy stays high from acceptance until the result is shown; the next item
// may be started in the cycle that the result is shown.
// After reset every entry is empty and all ages are zero.
// The receiver cannot stall, so a result is shown for exactly one cycle.
module assoc_cache_insertion_order_evict_core #(
	parameter int ENTRIES    = acioe_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = acioe_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = acioe_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  acioe_pkg::in_item_t  request,
	output logic                 result_valid,
	output acioe_pkg::out_item_t result
);
	import acioe_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	scan_ctl_t             chain_ctl   [ENTRIES+1];
	logic [KEY_BITS-1:0]   chain_key   [ENTRIES+1];
	logic [VALUE_BITS-1:0] chain_value [ENTRIES+1];
	logic [IDX_W-1:0]      chain_idx   [ENTRIES+1];

	logic      busy_q;
	logic      result_valid_q;
	out_item_t result_q;
	scan_ctl_t last_ctl;
	logic      commit_en;
	logic      is_hit;

	always_comb begin
		chain_ctl[0].act     = start && !busy_q;
		chain_ctl[0].cmd     = request.command;
		chain_ctl[0].done    = 1'b0;
		chain_ctl[0].sel_age = AGE_TOP;
	end
	assign chain_key[0]   = KEY_BITS'(request.key);
	assign chain_value[0] = VALUE_BITS'(request.payload);
	assign chain_idx[0]   = '0;

	assign last_ctl  = chain_ctl[ENTRIES];
	assign commit_en = last_ctl.act && last_ctl.cmd == CMD_INSERT;
	assign is_hit    = last_ctl.cmd == CMD_LOOKUP && last_ctl.done;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		acioe_cell #(
			.CELL_IDX  (g),
			.IDX_W     (IDX_W),
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_ctl      (chain_ctl[g]),
			.in_key      (chain_key[g]),
			.in_value    (chain_value[g]),
			.in_idx      (chain_idx[g]),
			.out_ctl     (chain_ctl[g+1]),
			.out_key     (chain_key[g+1]),
			.out_value   (chain_value[g+1]),
			.out_idx     (chain_idx[g+1]),
			.commit_en   (commit_en),
			.commit_idx  (chain_idx[ENTRIES]),
			.commit_key  (chain_key[ENTRIES]),
			.commit_value(chain_value[ENTRIES])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= last_ctl.act;
			if (last_ctl.act) begin
				busy_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last_ctl.act) begin
			result_q.hit         <= is_hit;
			result_q.slot        <= (is_hit || commit_en) ? SLOT_W'(chain_idx[ENTRIES]) : '0;
			result_q.evicted     <= commit_en && !last_ctl.done;
			result_q.found_value <= is_hit ? VALUE_W'(chain_value[ENTRIES]) : '0;
		end
	end

	assign busy         = busy_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/acioe_checker.sv]
// Port-level assertions for the insertion-order eviction cache, bound to the top level.
module acioe_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 result_valid,
	input acioe_pkg::out_item_t result
);
	import acioe_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an item was accepted");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("busy still high while a result is shown");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result shown in two cycles in a row");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !result_valid)
		else $error("result shown with no item in flight");

	a_hit_not_evict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit |-> !result.evicted)
		else $error("a result reports both a hit and an eviction");

endmodule

bind assoc_cache_insertion_order_evict_core acioe_checker u_acioe_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the fully associative cache with insertion-order eviction.
`timescale 1ns / 100ps

module tb;
	import acioe_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int POOL_SIZE    = 24;
	localparam int ENTRIES      = ENTRIES_DEF;

	class cache_mirror;
		logic               valid[ENTRIES];
		logic [KEY_W-1:0]   keys[ENTRIES];
		logic [VALUE_W-1:0] values[ENTRIES];
		logic [AGE_W-1:0]   ages[ENTRIES];
		out_item_t          pending_results[$];
		int errors, lookups, hits, inserts, evictions;

		function new();
			foreach (valid[i]) begin
				valid[i] = 1'b0;
				keys[i] = '0;
				values[i] = '0;
				ages[i] = '0;
			end
		endfunction

		function void note_request(in_item_t req);
			out_item_t want;
			int victim;
			want = '0;
			if (req.command == CMD_LOOKUP) begin
				lookups++;
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid[i] && keys[i] == req.key) begin
						want.hit = 1'b1;
						want.slot = SLOT_W'(i);
						want.found_value = values[i];
						hits++;
						break;
					end
				end
			end else begin
				inserts++;
				victim = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (!valid[i]) begin
						victim = i;
						break;
					end
				end
				if (victim < 0) begin
					victim = 0;
					for (int i = 1; i < ENTRIES; i++) begin
						if (ages[i] < ages[victim])
							victim = i;
					end
					want.evicted = 1'b1;
					evictions++;
				end
				for (int i = 0; i < ENTRIES; i++) begin
					if (i != victim && valid[i] && ages[i] != '0)
						ages[i] = ages[i] - 1'b1;
				end
				valid[victim] = 1'b1;
				keys[victim] = req.key;
				values[victim] = req.payload;
				ages[victim] = AGE_NEW;
				want.slot = SLOT_W'(victim);
			end
			pending_results.push_back(want);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("Result arrived with no item outstanding.");
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				errors++;
			end
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
				errors++;
			end
			if (got.found_value !== want.found_value) begin
				$error("found_value: expected %h, got %h", want.found_value, got.found_value);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  request;
	logic      result_valid;
	out_item_t result;
	int        cycles = 0;

	cache_mirror mirror = new();

	assoc_cache_insertion_order_evict_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				mirror.check_result(result);
			if (start && !busy)
				mirror.note_request(request);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(input in_item_t item, input int gap);
		in_item_t idle_item;
		@(negedge clk);
		start <= 1'b1;
		request <= item;
		do
			@(posedge clk);
		while (busy);
		if (gap > 0) begin
			@(negedge clk);
			idle_item.command = 1'($urandom);
			idle_item.key = $urandom;
			idle_item.payload = $urandom;
			start <= 1'b0;
			request <= idle_item;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (mirror.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		in_item_t         item;
		logic [KEY_W-1:0] pool[POOL_SIZE];
		int               insert_pct;
		bit               no_idle;

		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Misses on an empty store, then extreme keys and values.
		item.command = CMD_LOOKUP;
		item.key = '0;
		item.payload = '1;
		send_item(item, pick_gap());
		item.key = '1;
		send_item(item, pick_gap());
		item.command = CMD_INSERT;
		item.key = '0;
		item.payload = '1;
		send_item(item, pick_gap());
		item.key = '1;
		item.payload = '0;
		send_item(item, pick_gap());
		item.command = CMD_LOOKUP;
		item.key = '0;
		send_item(item, pick_gap());
		item.key = '1;
		send_item(item, pick_gap());
		// A second copy of a stored key; the lower entry must still win.
		item.command = CMD_INSERT;
		item.key = '0;
		item.payload = 32'h1234_5678;
		send_item(item, pick_gap());
		item.command = CMD_LOOKUP;
		send_item(item, pick_gap());
		// Fill the store, then force the oldest entry out.
		item.command = CMD_INSERT;
		for (int i = 3; i <= ENTRIES; i++) begin
			item.key = 32'hA5A5_0000 + i;
			item.payload = $urandom;
			send_item(item, pick_gap());
		end
		item.command = CMD_LOOKUP;
		item.key = '0;
		send_item(item, pick_gap());
		drain();

		foreach (pool[i])
			pool[i] = $urandom;
		pool[0] = '0;
		pool[1] = '1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0) begin
				insert_pct = $urandom_range(15, 85);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (n > 0 && n % 400 == 0)
				drain();
			if ($urandom_range(0, 19) == 0)
				pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			item.command = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_LOOKUP;
			item.key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
			item.payload = $urandom;
			send_item(item, no_idle ? 0 : pick_gap());
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d lookups with %0d hits and %0d inserts with %0d evictions.",
			mirror.lookups, mirror.hits, mirror.inserts, mirror.evictions);
		$display("Mismatches found: %0d.", mirror.errors);
		if (mirror.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[assoc_cache_insertion_order_evict_core.f]
rtl/acioe_pkg.sv
rtl/acioe_cell.sv
rtl/assoc_cache_insertion_order_evict_core.sv
rtl/acioe_checker.sv
sim/tb.sv
